FILE: hdl/bfsk_pkg.sv
`timescale 1ns / 1ps
package bfsk_pkg;

   localparam int unsigned MAX_HASHES = 7;
   localparam logic [31:0] MULT_RESET = 32'd12345;
   localparam logic [31:0] MULT_STEP = 32'd123;
   localparam logic [31:0] H1_MUL = 32'd25536;
   localparam logic [31:0] H5_MUL = 32'd12345;
   localparam logic [31:0] H6_MUL = 32'd345;
   localparam logic [31:0] H0_MUL = 32'd128;

   typedef struct packed {
      logic        action;
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } key_job_type;

   function automatic logic [31:0] mag32(input logic [31:0] u);
      mag32 = u[31] ? (32'd0 - u) : u;
   endfunction

endpackage

FILE: hdl/bfsk_cmod.sv
`timescale 1ns / 1ps
module bfsk_cmod #(
   parameter int unsigned HASH_RANGE = 80000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic [31:0] result
);
   import bfsk_pkg::*;

   // quotient estimate by reciprocal multiply, then one correction step
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(HASH_RANGE));
   localparam logic [31:0] RANGE_W = 32'(HASH_RANGE);

   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] fin_ff, fin_in;
   logic        s1_ff, s1_in;
   logic        s2_ff, s2_in;
   logic        s3_ff, s3_in;
   logic        done_ff, done_in;

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      fin_in  = fin_ff;
      s1_in   = start;
      s2_in   = s1_ff;
      s3_in   = s2_ff;
      done_in = s3_ff;
      if (start) begin
         mag_in = mag32(value);
         neg_in = value[31];
      end
      if (s1_ff) prod_in = 64'(mag_ff) * 64'(RECIP);
      if (s2_ff) rem_in = mag_ff - prod_ff[63:32] * RANGE_W;
      if (s3_ff) fin_in = (rem_ff >= RANGE_W) ? rem_ff - RANGE_W : rem_ff;
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      fin_ff  <= fin_in;
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         s3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = neg_ff ? (32'd0 - fin_ff) : fin_ff;

endmodule

FILE: hdl/bfsk_front.sv
`timescale 1ns / 1ps
module bfsk_front #(
   parameter int unsigned HASH_RANGE = 80000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [7:0]            req_key_byte,
   input  logic                  req_last_byte,
   output logic                  job_valid,
   input  logic                  job_ready,
   output bfsk_pkg::key_job_type job
);
   import bfsk_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_MOD1 = 6'b000100,
      S_MOD2 = 6'b001000,
      S_MOD3 = 6'b010000,
      S_PUSH = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] h_ff [7];
   logic [31:0] h_in [7];
   logic [31:0] m_ff, m_in;
   logic [31:0] c_ff, c_in;
   logic        last_ff, last_in;
   logic        act_ff, act_in;
   // products registered before the modulo unit
   logic [31:0] p1_ff, p1_in, p2_ff, p2_in, p5_ff, p5_in, p6_ff, p6_in;
   logic [31:0] cc_ff, cc_in, cube_ff, cube_in;
   logic [1:0]  sel_ff, sel_in;
   logic        md_start;
   logic [31:0] md_value;
   logic        md_done;
   logic [31:0] md_result;

   bfsk_cmod #(.HASH_RANGE(HASH_RANGE)) u_cmod (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .value (md_value),
      .done  (md_done),
      .result(md_result)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      m_in     = m_ff;
      c_in     = c_ff;
      last_in  = last_ff;
      act_in   = act_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p5_in    = p5_ff;
      p6_in    = p6_ff;
      cc_in    = cc_ff;
      cube_in  = cube_ff;
      sel_in   = sel_ff;
      md_start = 1'b0;
      md_value = p1_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               c_in     = {{24{req_key_byte[7]}}, req_key_byte};
               last_in  = req_last_byte;
               act_in   = req_action;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            p1_in   = H1_MUL * h_ff[1] + c_ff;
            p2_in   = m_ff * h_ff[2] + c_ff;
            p5_in   = h_ff[5] + H5_MUL * c_ff;
            p6_in   = H6_MUL * h_ff[6] + c_ff;
            cc_in   = c_ff * c_ff;
            h_in[0] = H0_MUL * h_ff[0] + c_ff;
            m_in    = m_ff * MULT_STEP;
            sel_in  = 2'd0;
            state_in = S_MOD1;
         end
         S_MOD1: begin
            // cube after c*c is registered; h3 is updated later in S_MOD2
            cube_in  = cc_ff * c_ff;
            md_start = 1'b1;
            md_value = p1_ff;
            state_in = S_MOD2;
         end
         S_MOD2: begin
            if (md_done) begin
               unique case (sel_ff)
                  2'd0: begin h_in[1] = md_result; md_value = p2_ff; end
                  2'd1: begin h_in[2] = md_result; md_value = p6_ff; end
                  2'd2: begin h_in[6] = md_result; md_value = p5_ff; end
                  default: begin md_value = p5_ff; end
               endcase
               if (sel_ff == 2'd3) begin
                  h_in[3] = h_ff[3] + cc_ff;
                  h_in[4] = h_ff[4] + mag32(cube_ff);
                  p5_in   = md_result;
                  state_in = S_MOD3;
               end else begin
                  md_start = 1'b1;
                  sel_in   = sel_ff + 2'd1;
               end
            end
         end
         S_MOD3: begin
            h_in[5] = h_ff[5] * p5_ff;
            state_in = last_ff ? S_PUSH : S_IDLE;
         end
         S_PUSH: begin
            if (job_ready) begin
               for (int i = 0; i < 7; i++) h_in[i] = 32'd1;
               m_in     = MULT_RESET;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      last_ff <= last_in;
      act_ff  <= act_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p5_ff   <= p5_in;
      p6_ff   <= p6_in;
      cc_ff   <= cc_in;
      cube_ff <= cube_in;
      sel_ff  <= sel_in;
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 7; i++) h_ff[i] <= 32'd1;
         m_ff <= MULT_RESET;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         m_ff     <= m_in;
      end
   end

   assign job_valid  = (state_ff == S_PUSH);
   assign job.action = act_ff;
   assign job.h0     = h_ff[0];
   assign job.h1     = h_ff[1];
   assign job.h2     = h_ff[2];
   assign job.h3     = h_ff[3];
   assign job.h4     = h_ff[4];
   assign job.h5     = h_ff[5];
   assign job.h6     = h_ff[6];

   a_push_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD3 && last_ff) |=> job_valid)
      else $error("key end did not produce a job");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !req_ready)
      else $error("request taken while a job is pending");
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      md_start |=> !md_done)
      else $error("modulo unit finished too early");

endmodule

FILE: hdl/bfsk_back.sv
`timescale 1ns / 1ps
module bfsk_back #(
   parameter int unsigned HASH_RANGE = 80000,
   parameter int unsigned NUM_HASHES = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  bfsk_pkg::key_job_type job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_present,
   output logic                  clearing
);
   import bfsk_pkg::*;

   localparam int unsigned AW = $clog2(HASH_RANGE);
   localparam int unsigned NH = (NUM_HASHES > MAX_HASHES) ? MAX_HASHES : NUM_HASHES;
   localparam int unsigned KW = 3;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MOD   = 7'b0000100,
      S_READ  = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type      state_ff, state_in;
   logic           store [HASH_RANGE];
   logic           rd_ff;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [31:0]    idx_ff [7];
   logic [31:0]    idx_in [7];
   logic [KW-1:0]  k_ff, k_in;
   logic           act_ff, act_in;
   logic           pres_ff, pres_in;
   logic           rspv_ff, rspv_in;
   logic           wr_en;
   logic           wr_val;
   logic           md_start;
   logic [31:0]    md_value;
   logic           md_done;
   logic [31:0]    md_result;
   logic           need_mod;

   bfsk_cmod #(.HASH_RANGE(HASH_RANGE)) u_cmod (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .value (md_value),
      .done  (md_done),
      .result(md_result)
   );

   assign need_mod = (k_ff == 3'd0) || (k_ff == 3'd3) || (k_ff == 3'd4) || (k_ff == 3'd5);
   assign job_ready = (state_ff == S_IDLE) && !rspv_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      act_in   = act_ff;
      pres_in  = pres_ff;
      rspv_in  = rspv_ff && !rsp_ready;
      wr_en    = 1'b0;
      wr_val   = 1'b0;
      md_start = 1'b0;
      md_value = idx_ff[k_ff];
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == AW'(HASH_RANGE - 1)) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (job_valid && !rspv_ff) begin
               idx_in[0] = job.h0;
               idx_in[1] = job.h1;
               idx_in[2] = job.h2;
               idx_in[3] = job.h3;
               idx_in[4] = job.h4;
               idx_in[5] = job.h5;
               idx_in[6] = job.h6;
               act_in   = job.action;
               pres_in  = 1'b1;
               k_in     = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            // reduce hash k to its index; modulo for the unreduced hashes
            if (need_mod) begin
               md_start = 1'b1;
               state_in = S_READ;
            end else begin
               idx_in[k_ff] = mag32(idx_ff[k_ff]);
               state_in = S_CHECK;
            end
         end
         S_READ: begin
            if (md_done) begin
               idx_in[k_ff] = mag32(md_result);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // wait state for the registered read
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rd_ff || idx_ff[k_ff] >= 32'(HASH_RANGE)) pres_in = 1'b0;
            if (k_ff == KW'(NH - 1)) begin
               k_in     = '0;
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = S_MOD;
            end
         end
         S_DONE: begin
            // set pass over the held indices on insert
            if (act_ff && idx_ff[k_ff] < 32'(HASH_RANGE)) begin
               wr_en  = 1'b1;
               wr_val = 1'b1;
            end
            if (!act_ff || k_ff == KW'(NH - 1)) begin
               rspv_in  = 1'b1;
               k_in     = '0;
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (state_ff == S_CLEAR) store[addr_ff] <= 1'b0;
         else store[idx_ff[k_ff][AW-1:0]] <= wr_val;
      end
      rd_ff <= store[idx_ff[k_ff][AW-1:0]];
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      k_ff   <= k_in;
      act_ff <= act_in;
      pres_ff <= pres_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rspv_ff  <= rspv_in;
      end
   end

   assign rsp_valid   = rspv_ff;
   assign rsp_present = pres_ff;
   assign clearing    = (state_ff == S_CLEAR);

   a_no_job_while_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !job_ready)
      else $error("job accepted during clear");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rspv_ff) |-> $past(state_ff == S_DONE))
      else $error("response without finished probe");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_en)
      else $error("store written while idle");

endmodule

FILE: hdl/bfsk_queue.sv
`timescale 1ns / 1ps
module bfsk_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bfsk_pkg::key_job_type in_job,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bfsk_pkg::key_job_type out_job
);
   import bfsk_pkg::*;

   // two-entry queue between front and back
   key_job_type ent_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = ent_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wp_ff] <= in_job;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready)
      else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count slip");
   a_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointer mismatch");

endmodule

FILE: hdl/bloom_filter_string_keys.sv
`timescale 1ns / 1ps
// bloom filter over byte-string keys, seven hashes
// request channel: one key byte per request (req_key_byte), req_last_byte
// marks the final byte, req_action on that byte picks query (0) or insert (1)
// response channel: one rsp_present per key, 1 when all hashed bits were set
// before the key; an insert then sets them
// front end: takes a byte only when idle; each byte makes four passes through
// the reciprocal modulo unit, and a finished key then enters a two-entry queue
// from a push state that waits while the queue is full
// back end: four of the hashes need a pass through its own modulo unit and the
// others do not, with one registered store read for each; an insert then sets
// the bit of each hash before the response
// reset: hashes return to their start values and the 80000-bit store is
// cleared by a pass over every address, during which keys wait in the queue
// a stalled response holds the back end; the front end keeps taking bytes
// until the queue is full
module bloom_filter_string_keys #(
   parameter int unsigned HASH_RANGE = 80000,
   parameter int unsigned NUM_HASHES = 7
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_key_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_present
);
   import bfsk_pkg::*;

   logic        f_valid, f_ready, b_valid, b_ready, clearing;
   key_job_type f_job, b_job;

   bfsk_front #(.HASH_RANGE(HASH_RANGE)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_key_byte (req_key_byte),
      .req_last_byte(req_last_byte),
      .job_valid    (f_valid),
      .job_ready    (f_ready),
      .job          (f_job)
   );

   bfsk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_job   (f_job),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_job  (b_job)
   );

   bfsk_back #(.HASH_RANGE(HASH_RANGE), .NUM_HASHES(NUM_HASHES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (b_valid),
      .job_ready  (b_ready),
      .job        (b_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_present(rsp_present),
      .clearing   (clearing)
   );

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("response during store clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_present))
      else $error("response dropped");
   a_q_flow: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !b_ready)
      else $error("queue drained during clear");

endmodule

FILE: bench/bloom_filter_string_keys_tb.sv
`timescale 1ns / 1ps
module bloom_filter_string_keys_tb;

   localparam int unsigned RANGE = 80000;
   localparam int unsigned HASHES = 7;
   localparam int unsigned MAX_KEY = 16;
   localparam int unsigned TAIL_CYCLES = 600;

   typedef enum int {CHECK_OK, CHECK_UNEXPECTED, CHECK_WRONG} check_code_type;
   typedef enum logic {ACT_QUERY = 1'b0, ACT_INSERT = 1'b1} action_type;

   typedef struct {
      logic [8*MAX_KEY-1:0] bytes;
      int                   len;
   } key_type;

   class BloomScoreboard;
      bit          store_bits[RANGE];
      logic [31:0] acc[7];
      logic [31:0] mult;
      bit          presence_q[$];
      bit          last_expected;

      function new();
         foreach (store_bits[i]) store_bits[i] = 1'b0;
         restart();
      endfunction

      function void restart();
         foreach (acc[i]) acc[i] = 32'd1;
         mult = 32'd12345;
      endfunction

      function logic [31:0] magnitude(input logic [31:0] u);
         return u[31] ? (32'd0 - u) : u;
      endfunction

      function logic [31:0] fold_range(input logic [31:0] u);
         logic [31:0] r;
         r = magnitude(u) % RANGE;
         return u[31] ? (32'd0 - r) : r;
      endfunction

      function void absorb(input logic [7:0] b);
         logic [31:0] c;
         c = {{24{b[7]}}, b};
         acc[0] = 32'd128 * acc[0] + c;
         acc[1] = fold_range(32'd25536 * acc[1] + c);
         acc[2] = fold_range(mult * acc[2] + c);
         mult = mult * 32'd123;
         acc[3] = acc[3] + c * c;
         acc[4] = acc[4] + magnitude(c * c * c);
         acc[5] = acc[5] * fold_range(acc[5] + 32'd12345 * c);
         acc[6] = fold_range(32'd345 * acc[6] + c);
      endfunction

      function void note_request(input logic act, input logic [7:0] b, input logic last);
         logic [31:0] idx[7];
         bit          hit;
         absorb(b);
         if (!last) return;
         hit = 1'b1;
         for (int k = 0; k < HASHES; k++) begin
            if (k == 1 || k == 2 || k == 6) idx[k] = magnitude(acc[k]);
            else idx[k] = magnitude(fold_range(acc[k]));
            if (idx[k] >= RANGE || !store_bits[idx[k]]) hit = 1'b0;
         end
         if (act == ACT_INSERT) begin
            for (int k = 0; k < HASHES; k++)
               if (idx[k] < RANGE) store_bits[idx[k]] = 1'b1;
         end
         presence_q.push_back(hit);
         restart();
      endfunction

      function check_code_type check_response(input logic present);
         if (presence_q.size() == 0) return CHECK_UNEXPECTED;
         last_expected = presence_q.pop_front();
         if (present !== last_expected) return CHECK_WRONG;
         return CHECK_OK;
      endfunction

      function int pending();
         return presence_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   logic [7:0] req_key_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_present;

   BloomScoreboard bloom_sb;
   int errors;
   int bytes_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_len;
   key_type pool[$];

   bloom_filter_string_keys u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_key_byte(req_key_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_present(rsp_present)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #40000000;
      $display("Verification failed");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   // response side
   initial begin
      check_code_type code;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            code = bloom_sb.check_response(rsp_present);
            if (code == CHECK_UNEXPECTED)
               report("response with no request pending");
            else if (code == CHECK_WRONG)
               report($sformatf("present %0b, expected %0b", rsp_present,
                  bloom_sb.last_expected));
         end
         if (hold_len > 0) begin
            hold_len--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic act, input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      bloom_sb.note_request(act, b, last);
      bytes_sent++;
   endtask

   task automatic send_key(input key_type k, input logic act);
      for (int i = 0; i < k.len; i++) begin
         if (i == k.len - 1) send_byte(act, k.bytes[8*i +: 8], 1'b1);
         else send_byte(1'($urandom_range(1)), k.bytes[8*i +: 8], 1'b0);
      end
   endtask

   function automatic key_type random_key();
      key_type k;
      k.bytes = '0;
      k.len = ($urandom_range(9) == 0) ? $urandom_range(MAX_KEY, 7) : $urandom_range(6, 1);
      for (int i = 0; i < k.len; i++) k.bytes[8*i +: 8] = 8'($urandom_range(255, 1));
      return k;
   endfunction

   function automatic key_type fill_key(input logic [7:0] b, input int len);
      key_type k;
      k.bytes = '0;
      k.len = len;
      for (int i = 0; i < len; i++) k.bytes[8*i +: 8] = b;
      return k;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (bloom_sb.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic random_keys(input int upto);
      key_type k;
      while (bytes_sent < upto) begin
         if (pool.size() > 0 && $urandom_range(1)) begin
            k = pool[$urandom_range(pool.size() - 1)];
            send_key(k, $urandom_range(3) == 0 ? ACT_INSERT : ACT_QUERY);
         end else begin
            k = random_key();
            if ($urandom_range(4) < 3) begin
               send_key(k, ACT_INSERT);
               pool.push_back(k);
            end else begin
               send_key(k, ACT_QUERY);
            end
         end
      end
   endtask

   initial begin
      key_type k;
      bloom_sb = new();
      errors = 0;
      bytes_sent = 0;
      hold_len = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = 1'b0;
      req_key_byte = 8'd1;
      req_last_byte = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed keys: extremes, single byte, long, insert then query
      k = fill_key(8'h01, 1);
      send_key(k, ACT_QUERY);
      send_key(k, ACT_INSERT);
      send_key(k, ACT_QUERY);
      k = fill_key(8'hff, 1);
      send_key(k, ACT_QUERY);
      k.bytes = '0;
      k.len = 2;
      k.bytes[15:0] = 16'h7f80;
      send_key(k, ACT_INSERT);
      send_key(k, ACT_QUERY);
      k = fill_key(8'hff, MAX_KEY);
      send_key(k, ACT_INSERT);
      send_key(k, ACT_QUERY);
      k = fill_key(8'h80, 3);
      send_key(k, ACT_QUERY);
      wait_idle();

      send_idle_pct = 31;
      recv_idle_pct = 46;
      random_keys(600);
      // sender waits for every response
      wait_idle();
      send_idle_pct = 46;
      recv_idle_pct = 31;
      random_keys(1100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold while the sender keeps going
      hold_len = 5000;
      random_keys(1600);
      wait_idle();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/bfsk_pkg.sv
hdl/bfsk_cmod.sv
hdl/bfsk_front.sv
hdl/bfsk_back.sv
hdl/bfsk_queue.sv
hdl/bloom_filter_string_keys.sv
bench/bloom_filter_string_keys_tb.sv
